FILE: hw/rtl/lkpm_pkg.sv
package lkpm_pkg;

  localparam int KW_TABLE         = 8;
  localparam int KW_MAX_LEN       = 23;
  localparam int KW_TEXT_W        = KW_MAX_LEN * 8;
  localparam int NUM_KEYWORDS_DEF = 8;
  localparam int MAX_LINE_DEF     = 32;

  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef struct packed {
    logic       found;
    logic [2:0] index;
  } lkpm_res_t;

  // Each keyword sits right-aligned: its last character is in the low byte.
  localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_TABLE] = '{
    KW_TEXT_W'({"led_all", "_on"}),
    KW_TEXT_W'({"led_all", "_off"}),
    KW_TEXT_W'({"shift_left", "_led_on"}),
    KW_TEXT_W'({"shift_right", "_led_on"}),
    KW_TEXT_W'({"shift_left", "_keep_led_on"}),
    KW_TEXT_W'({"shift_right", "_keep_led_on"}),
    KW_TEXT_W'({"flower", "_on"}),
    KW_TEXT_W'({"flower", "_off"})
  };

  localparam logic [4:0] KW_LEN [KW_TABLE] = '{
    5'd10, 5'd11, 5'd17, 5'd18, 5'd22, 5'd23, 5'd9, 5'd10
  };

  // Character of keyword k at position p; valid only for p below the keyword length.
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [4:0] p);
    logic [KW_TEXT_W-1:0] txt;
    logic [4:0]           sh;
    txt = KW_TEXT[k];
    sh  = KW_LEN[k] - 5'd1 - p;
    if (p < KW_LEN[k]) begin
      kw_char = txt[{sh, 3'b000} +: 8];
    end else begin
      kw_char = 8'h00;
    end
  endfunction

endpackage

FILE: hw/rtl/line_keyword_prefix_matcher.sv
// Line keyword prefix matcher.
// Input channel: one received byte per beat on in_rx_byte (in_valid/in_ready).
// Bytes are grouped into lines ended by 0x0A. At each newline the block tests
// whether the line starts with one of the first NumKeywords (at most eight)
// fixed command keywords, in table order, and emits one result beat: out_found
// and out_keyword_index (the first matching keyword, 0 when nothing matched).
// Other bytes give no result. A newline held in the input register moves its
// result into the result register once that is free or being drained.
// Throughput: one byte per cycle unless a newline waits on a held result; the
// per-byte compare of all keyword characters at a position is combinational.
// Reset (rst_n low, synchronous) empties both register stages, clears the line
// position and marks every keyword as still matching.
// When the receiver stalls, the result is held; ordinary bytes keep flowing
// through the input register, and only a second newline waits until the
// held result is taken.
module line_keyword_prefix_matcher #(
  parameter int NumKeywords = lkpm_pkg::NUM_KEYWORDS_DEF,
  parameter int MaxLine     = lkpm_pkg::MAX_LINE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_found,
  output logic [2:0] out_keyword_index
);
  import lkpm_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       out_valid_r, out_valid_nxt;
  lkpm_res_t  res_r;
  lkpm_res_t  res;
  logic       s1_nl;
  logic       s1_go;

  assign s1_nl = (in_byte_r == NEWLINE);
  // A newline advances only if the result register is free or being drained.
  assign s1_go = in_valid_r && (!s1_nl || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || s1_go;

  lkpm_match #(
    .NumKeywords(NumKeywords),
    .MaxLine    (MaxLine)
  ) u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .step_i(s1_go),
    .byte_i(in_byte_r),
    .res_o (res)
  );

  always_comb begin
    in_valid_nxt = in_ready ? in_valid : in_valid_r;
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_nl) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    if (s1_go && s1_nl) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = res_r.found;
  assign out_keyword_index = res_r.index;

endmodule

FILE: hw/rtl/lkpm_match.sv
module lkpm_match #(
  parameter int NumKeywords = lkpm_pkg::NUM_KEYWORDS_DEF,
  parameter int MaxLine     = lkpm_pkg::MAX_LINE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output lkpm_pkg::lkpm_res_t   res_o
);
  import lkpm_pkg::*;

  localparam int NumActive = (NumKeywords < KW_TABLE) ? NumKeywords : KW_TABLE;
  localparam int PosW      = $clog2(MaxLine + 1);

  logic [PosW-1:0]      pos_r, pos_nxt;
  logic [NumActive-1:0] alive_r, alive_nxt;
  logic                 is_nl;

  assign is_nl = (byte_i == NEWLINE);

  // First keyword in table order whose flag survived and whose length was reached.
  always_comb begin
    res_o = '0;
    for (int k = NumActive - 1; k >= 0; k--) begin
      if (alive_r[k] && (6'(pos_r) >= {1'b0, KW_LEN[k]})) begin
        res_o.found = 1'b1;
        res_o.index = 3'(k);
      end
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    alive_nxt = alive_r;
    if (step_i) begin
      if (is_nl) begin
        pos_nxt   = '0;
        alive_nxt = '1;
      end else if (pos_r < PosW'(MaxLine)) begin
        for (int k = 0; k < NumActive; k++) begin
          if ((6'(pos_r) < {1'b0, KW_LEN[k]}) &&
              (kw_char(3'(k), pos_r[4:0]) != byte_i)) begin
            alive_nxt[k] = 1'b0;
          end
        end
        pos_nxt = pos_r + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      alive_r <= '1;
    end else begin
      pos_r   <= pos_nxt;
      alive_r <= alive_nxt;
    end
  end

endmodule

FILE: hw/rtl/lkpm_checker.sv
module lkpm_checker #(
  parameter int NumKeywords = lkpm_pkg::NUM_KEYWORDS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_found,
  input logic [2:0] out_keyword_index
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
                                $stable(out_keyword_index))
    else $error("result beat changed while stalled");

  // No result beat right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_keyword_index == 3'd0)
    else $error("nonzero index without a match");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> 5'(out_keyword_index) < 5'(NumKeywords))
    else $error("index beyond active keywords");

  // With the result register empty, nothing can block the input side.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

endmodule

bind line_keyword_prefix_matcher lkpm_checker #(.NumKeywords(NumKeywords)) u_lkpm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_found        (out_found),
  .out_keyword_index(out_keyword_index)
);
